>>> rtl/assert_macros.svh
// Assertion macros included by the profiler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/sscp_pkg.sv
// ----------------------------------------------------------------------------
// S-curve profiler package
// Shared types, codes and constants of the step-pulse profiler.
// ----------------------------------------------------------------------------
package sscp_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned TableAw = $clog2(TableDepth);
  localparam int unsigned PosBits = 24;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_STEPS = 2'd1,
    MODE_PER   = 2'd2,
    MODE_START = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_ACCEL_LEN = 3'd0,
    REG_DECEL_LEN = 3'd1,
    REG_LAP       = 3'd2,
    REG_DIVISOR   = 3'd3,
    REG_HOLD      = 3'd4,
    REG_FWD_LEVEL = 3'd5
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_STEP,
    ST_PER,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

>>> rtl/stepper_s_curve_profiler.sv
// ----------------------------------------------------------------------------
// Stepper S-curve profiler
// Table-driven step-pulse profiler with an iterative position divider.
// ----------------------------------------------------------------------------
// Each transaction passes through ST_READ, ST_STEP, ST_PER, the ST_DIV loop of the
// 24-step restoring divider that turns pulse position into step position, and ST_OUT,
// where the result is held until taken; a new transaction is accepted only in ST_IDLE.
// Tables are read through one registered port each.
// Reset sets all control state to its defaults; table contents are undefined until written.
module stepper_s_curve_profiler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  table_index_i,
  input  logic [15:0] table_value_i,
  input  logic        direction_i,
  input  logic [23:0] move_pulses_i,
  input  logic [23:0] accel_pulses_i,
  input  logic [23:0] decel_pulses_i,
  input  logic [23:0] mirror_point_i,
  input  logic [7:0]  hold_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] position_pulses_o,
  output logic [23:0] position_steps_o,
  output logic [15:0] period_o,
  output logic [14:0] compare_o,
  output logic        running_o,
  output logic [31:0] elapsed_time_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [24:0] cfg_data_i
);
  import sscp_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned DivBits = 24;

  logic [15:0] steps_mem [TableDepth];
  logic [15:0] per_mem [TableDepth];
  logic [15:0] steps_rd_q, per_rd_q;
  logic [TableAw-1:0] steps_addr, per_addr;
  logic steps_we, per_we;

  logic [7:0] accel_len_q, decel_len_q;
  logic [24:0] lap_q;
  logic [15:0] div_q;
  logic hold_en_q, fwd_q;

  state_e state_q, state_d;
  logic [1:0] mode_q;
  logic [7:0] tidx_q;
  logic [15:0] tval_q;

  logic [23:0] move_q, accel_q, decel_q, mirror_q;
  logic [7:0] hold_idx_q;
  logic dir_q;

  logic [7:0] speed_q;
  logic [15:0] seg_q;
  logic [23:0] done_q;
  logic [23:0] pos_q;
  logic active_q;
  logic [15:0] period_q;
  logic [31:0] time_q;

  logic [23:0] quo_q;
  logic [16:0] rem_q;
  logic [4:0] cnt_q;
  logic [23:0] steps_out_q;

  logic upd_q, acc_q, stop_q;
  logic [15:0] per_new;

  // Stepping work done in ST_STEP, with the step count of speed_q available.
  logic [23:0] done_n;
  logic [15:0] seg_n;
  logic [8:0] ends;
  logic [9:0] idx;
  logic climb, ramp_down, held, stop;
  logic [7:0] speed_n;
  logic [23:0] pos_n;
  logic [24:0] lap_eff, pos_inc;

  always_comb begin
    lap_eff = (lap_q == '0) ? 25'd1 : ((lap_q > 25'h1000000) ? 25'h1000000 : lap_q);
    pos_inc = {1'b0, pos_q} + 25'd1;
    if (dir_q == fwd_q) begin
      pos_n = (pos_inc >= lap_eff) ? '0 : pos_inc[23:0];
    end else begin
      pos_n = (pos_q == '0) ? 24'(lap_eff - 25'd1) : pos_q - 24'd1;
    end
    ends = {1'b0, accel_len_q} + {1'b0, decel_len_q};
    held = hold_en_q && ((speed_q == hold_idx_q) ||
           ({1'b0, hold_idx_q} + {1'b0, speed_q} == ends - 9'd1));
    done_n = done_q + 24'd1;
    seg_n = (done_n == mirror_q) ? steps_rd_q : seg_q + 16'd1;
    climb = 1'b0;
    ramp_down = 1'b0;
    idx = {2'b0, speed_q};
    if (seg_n >= steps_rd_q) begin
      climb = (done_n <= accel_q) &&
              ($signed({2'b0, speed_q}) < $signed({2'b0, accel_len_q} - 10'd1));
      if (climb) idx = idx + 10'd1;
      ramp_down = (done_n <= move_q) && (move_q - done_n <= decel_q) &&
                  (hold_en_q || done_n >= (move_q >> 1));
      if (ramp_down) begin
        if ($signed(idx) < $signed({2'b0, accel_len_q} - 10'd1)) idx = {1'b0, ends} - idx;
        idx = idx + 10'd1;
        if ($signed(idx) >= $signed({1'b0, ends})) idx = {1'b0, ends} - 10'd1;
      end
      if ($signed(idx) < 0) idx = '0;
    end
    speed_n = idx[7:0];
    stop = (done_n >= move_q) && (done_n > 24'd3);
  end

  logic do_update;
  assign do_update = (seg_n >= steps_rd_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_READ;
      ST_READ: state_d = ST_STEP;
      ST_STEP: state_d = ST_PER;
      ST_PER:  state_d = ST_DIV;
      ST_DIV:  if (cnt_q == 5'(DivBits - 1)) state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    steps_we = (state_q == ST_READ) && (mode_q == MODE_STEPS);
    per_we = (state_q == ST_READ) && (mode_q == MODE_PER);
    steps_addr = steps_we ? tidx_q : speed_q;
    // The step cycle reads the period of the index that the tick moves to.
    if (state_q == ST_READ) begin
      per_addr = (mode_q == MODE_START) ? '0 : tidx_q;
    end else if (state_q == ST_STEP) begin
      per_addr = speed_n;
    end else begin
      per_addr = speed_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (steps_we) steps_mem[steps_addr] <= tval_q;
    steps_rd_q <= steps_mem[steps_addr];
    if (per_we) per_mem[per_addr] <= tval_q;
    per_rd_q <= per_mem[per_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_len_q <= 8'd1;
      decel_len_q <= 8'd1;
      lap_q <= 25'h1000000;
      div_q <= 16'd1;
      hold_en_q <= 1'b0;
      fwd_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ACCEL_LEN: accel_len_q <= cfg_data_i[7:0];
        REG_DECEL_LEN: decel_len_q <= cfg_data_i[7:0];
        REG_LAP:       lap_q <= cfg_data_i;
        REG_DIVISOR:   div_q <= cfg_data_i[15:0];
        REG_HOLD:      hold_en_q <= cfg_data_i[0];
        REG_FWD_LEVEL: fwd_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [16:0] rem_sh, dvs;
  assign dvs = (div_q == '0) ? 17'd1 : {1'b0, div_q};
  assign rem_sh = {rem_q[15:0], quo_q[23]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q <= MODE_TICK;
      speed_q <= '0;
      seg_q <= '0;
      done_q <= '0;
      pos_q <= '0;
      active_q <= 1'b0;
      period_q <= '0;
      time_q <= '0;
      move_q <= '0;
      accel_q <= '0;
      decel_q <= '0;
      mirror_q <= '0;
      hold_idx_q <= '0;
      dir_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            mode_q <= mode_i;
            if (mode_i == MODE_START) begin
              move_q <= move_pulses_i;
              accel_q <= accel_pulses_i;
              decel_q <= decel_pulses_i;
              mirror_q <= mirror_point_i;
              hold_idx_q <= hold_index_i;
              dir_q <= direction_i;
            end
          end
        end
        ST_STEP: begin
          // steps_rd_q holds the step count of speed_q (or the start read).
          if (mode_q == MODE_START) begin
            speed_q <= '0;
            seg_q <= '0;
            done_q <= '0;
            time_q <= '0;
            period_q <= per_rd_q;
            active_q <= 1'b1;
          end else if (mode_q == MODE_TICK && active_q) begin
            pos_q <= pos_n;
            if (!held) begin
              done_q <= done_n;
              seg_q <= (do_update && (climb || ramp_down)) ? '0 : seg_n;
              if (do_update) speed_q <= speed_n;
              if (stop) begin
                active_q <= 1'b0;
              end
            end
          end
        end
        ST_PER: begin
          // Period of the new index was read in the step cycle's aftermath.
          cnt_q <= '0;
          period_q <= per_new;
          if (acc_q) time_q <= time_q + {16'd0, per_new};
          if (stop_q) speed_q <= '0;
        end
        ST_DIV: cnt_q <= cnt_q + 5'd1;
        default: ;
      endcase
    end
  end

  // Period refresh and time accumulation need the period read at the new index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_q <= 1'b0;
      acc_q <= 1'b0;
      stop_q <= 1'b0;
    end else if (state_q == ST_STEP) begin
      upd_q <= (mode_q == MODE_TICK) && active_q && !held && do_update;
      acc_q <= (mode_q == MODE_TICK) && active_q && !held && !stop;
      stop_q <= (mode_q == MODE_TICK) && active_q && !held && stop;
    end else if (state_q == ST_PER) begin
      upd_q <= 1'b0;
      acc_q <= 1'b0;
      stop_q <= 1'b0;
    end
  end

  assign per_new = upd_q ? per_rd_q : period_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      tidx_q <= table_index_i;
      tval_q <= table_value_i;
    end
    if (state_q == ST_PER) begin
      quo_q <= pos_q;
      rem_q <= '0;
    end else if (state_q == ST_DIV) begin
      if (rem_sh >= dvs) begin
        rem_q <= rem_sh - dvs;
        quo_q <= {quo_q[22:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[22:0], 1'b0};
      end
      if (cnt_q == 5'(DivBits - 1)) steps_out_q <= (rem_sh >= dvs) ?
          {quo_q[22:0], 1'b1} : {quo_q[22:0], 1'b0};
    end
  end

  assign position_pulses_o = pos_q;
  assign position_steps_o = steps_out_q;
  assign period_o = period_q;
  assign compare_o = period_q[15:1];
  assign running_o = active_q;
  assign elapsed_time_o = time_q;

  `CHK_IMPL(a_in_only_idle, in_ready_o, !out_valid_o, "input and output both open")
  `CHK_IMPL(a_div_len, state_q == ST_DIV, cnt_q < 5'(DivBits), "divider overran")
  `CHK_IMPL(a_out_hold, out_valid_o && !out_ready_i, ##1 out_valid_o, "result dropped")
endmodule
